// File: hw/rtl/tsis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsis_pkg
// Shared types and constants for the insertion sorter and its cell chain.
// ----------------------------------------------------------------------------
package tsis_pkg;

  localparam int MAX_ITEMS_DEF = 16;
  localparam int VALUE_W       = 32;

  // One input transaction.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      end_of_run;
    logic                      overflow;
  } out_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the broadcast value this cycle
    logic drain;  // shift every cell one place toward the head
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

// File: hw/rtl/tsis_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsis_cell
// One slot of the sorted chain: holds a value, compares it with the value
// being inserted and takes its left or right neighbor's value when told.
// ----------------------------------------------------------------------------
module tsis_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                                clk,
  input  tsis_pkg::cell_ctl_t                 ctl,
  input  logic [CNT_W-1:0]                    count,
  input  logic signed [tsis_pkg::VALUE_W-1:0] v,
  input  logic signed [tsis_pkg::VALUE_W-1:0] left_val,
  input  logic                                left_gt,
  input  logic signed [tsis_pkg::VALUE_W-1:0] right_val,
  output logic signed [tsis_pkg::VALUE_W-1:0] val,
  output logic                                gt
);
  import tsis_pkg::*;

  logic occupied;
  logic is_tail;

  assign occupied = CNT_W'(IDX) < count;
  assign is_tail  = CNT_W'(IDX) == count;
  // Strictly greater, so a new value lands after any equal ones.
  assign gt       = occupied && (val > v);

  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      val <= right_val;
    end else if (ctl.ins && (gt || is_tail)) begin
      val <= left_gt ? left_val : v;
    end
  end

endmodule

// File: hw/rtl/two_stack_insertion_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_insertion_sorter
// Batch sorter for signed 32-bit values built as a chain of insertion cells.
// ----------------------------------------------------------------------------
// Values are loaded one per clock cycle while busy is low: each accepted
// transaction that finds room is inserted into the chain in that same cycle.
// When the transaction marked is_last has been accepted, busy rises on the
// next cycle and the block emits the n stored values in ascending order, one
// per cycle with strobe high; the receiver cannot stall, so every result
// must be taken in the cycle it is shown. The load rate is set by the
// per-cell signed 32-bit compare against the broadcast value and the
// neighbor select behind it; the output rate by the one-place shift of the
// chain toward its head. Values arriving once MAX_ITEMS are stored are
// dropped and every result of that batch carries overflow. end_of_run marks
// the final result, after which busy falls and the block is empty again.
// ----------------------------------------------------------------------------
module two_stack_insertion_sorter #(
  parameter int MAX_ITEMS = tsis_pkg::MAX_ITEMS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  tsis_pkg::in_t  item,
  output logic           busy,
  output logic           strobe,
  output tsis_pkg::out_t result
);
  import tsis_pkg::*;

  // The count must be able to hold MAX_ITEMS itself.
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             accept;
  logic             room;
  cell_ctl_t        ctl;

  logic signed [VALUE_W-1:0] vals [MAX_ITEMS];
  logic                      gts  [MAX_ITEMS];

  assign accept = start && !busy;
  assign room   = count < CNT_W'(MAX_ITEMS);

  // Next-state logic: a load phase that ends with the last transaction of a
  // batch, and an output phase that ends when the final value leaves.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && item.is_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (count == CNT_W'(1)) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Output logic for the state machine. Busy is low throughout the load
  // phase, so start alone marks an accepted transaction there.
  always_comb begin
    busy      = 1'b0;
    strobe    = 1'b0;
    ctl.ins   = 1'b0;
    ctl.drain = 1'b0;
    case (state)
      ST_LOAD: begin
        ctl.ins = start && room;
      end
      ST_DRAIN: begin
        busy      = 1'b1;
        strobe    = 1'b1;
        ctl.drain = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.ins) begin
        count <= count + CNT_W'(1);
      end else if (ctl.drain) begin
        count <= count - CNT_W'(1);
      end
      // A dropped value marks the whole batch; the flag clears as the
      // final result leaves.
      if (accept && !room) begin
        ovf <= 1'b1;
      end else if (ctl.drain && count == CNT_W'(1)) begin
        ovf <= 1'b0;
      end
    end
  end

  // The head cell always holds the smallest remaining value.
  assign result.sorted_value = vals[0];
  assign result.end_of_run   = count == CNT_W'(1);
  assign result.overflow     = ovf;

  // Chain of cells. On insert, every cell holding a value greater than the
  // broadcast one moves one place toward the tail, and the first such cell
  // (or the first empty cell) takes the new value. On drain, the chain
  // shifts one place toward the head.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val;
    logic                      left_gt;
    logic signed [VALUE_W-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_val = vals[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    tsis_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .v         (item.value),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

endmodule

// File: sim/two_stack_insertion_sorter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_insertion_sorter_checker
// Predicts and checks every result transaction of the insertion sorter.
// ----------------------------------------------------------------------------
// Keeps its own sorted copy of the current batch. It emits the expected run
// when the value marked is_last is accepted, and compares each strobed result
// with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module two_stack_insertion_sorter_checker #(
  parameter int MAX_ITEMS = tsis_pkg::MAX_ITEMS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  tsis_pkg::in_t  item,
  input  logic           strobe,
  input  tsis_pkg::out_t result,
  output int             fail_count,
  output int             pending,
  output int             results_seen
);
  import tsis_pkg::*;

  logic signed [VALUE_W-1:0] batch_sorted [MAX_ITEMS];
  int                        batch_count;
  logic                      batch_dropped;
  out_t                      sorted_run_q [$];

  // Insert after any equal values so that the copy stays ascending.
  function automatic void place_value(input logic signed [VALUE_W-1:0] v);
    int pos;
    pos = batch_count;
    while (pos > 0 && batch_sorted[pos-1] > v) begin
      batch_sorted[pos] = batch_sorted[pos-1];
      pos--;
    end
    batch_sorted[pos] = v;
    batch_count++;
  endfunction

  function automatic void release_batch();
    out_t run_entry;
    for (int k = 0; k < batch_count; k++) begin
      run_entry.sorted_value = batch_sorted[k];
      run_entry.end_of_run   = (k == batch_count - 1);
      run_entry.overflow     = batch_dropped;
      sorted_run_q.push_back(run_entry);
    end
    batch_count   = 0;
    batch_dropped = 1'b0;
  endfunction

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    batch_count  = 0;
    batch_dropped = 1'b0;
  end

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      batch_count   = 0;
      batch_dropped = 1'b0;
      sorted_run_q.delete();
    end else begin
      if (strobe) begin
        results_seen++;
        if (sorted_run_q.size() == 0) begin
          $error("result with no transaction expected: sorted_value %0d",
                 result.sorted_value);
          fail_count++;
        end else begin
          want = sorted_run_q.pop_front();
          if (result.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d",
                   want.sorted_value, result.sorted_value);
            fail_count++;
          end
          if (result.end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0b, got %0b",
                   want.end_of_run, result.end_of_run);
            fail_count++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b",
                   want.overflow, result.overflow);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (batch_count < MAX_ITEMS) place_value(item.value);
        else batch_dropped = 1'b1;
        if (item.is_last) release_batch();
      end
    end
    pending = sorted_run_q.size();
  end

endmodule

// File: sim/two_stack_insertion_sorter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_insertion_sorter_tb
// Self-checking testbench for the batch insertion sorter.
// ----------------------------------------------------------------------------
// Sends batches of signed values, each closed by a transaction marked
// is_last, and lets a checker beside the block predict the sorted run and
// compare every result. A directed opening covers the extremes, duplicates
// and a batch that overflows on its closing value; random batches follow in
// three phases of sender idling.
// ----------------------------------------------------------------------------
module two_stack_insertion_sorter_tb;
  import tsis_pkg::*;

  localparam int CAPACITY    = MAX_ITEMS_DEF;
  // The longest quiet stretch of a correct run is a sender gap at the high
  // idle rate; this limit is many times that.
  localparam int QUIET_LIMIT = 2000;
  // After the last expected result, allow a full drain of the chain.
  localparam int TAIL_CYCLES = 2 * CAPACITY + 8;
  localparam int PHASE_ITEMS = 145;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  in_t  item  = '0;
  logic busy;
  logic strobe;
  out_t result;

  int fail_count;
  int pending;
  int results_seen;

  int send_idle_pct    = 0;
  int items_sent       = 0;
  int batches_sent     = 0;
  int overflow_batches = 0;
  int quiet_cycles     = 0;

  always #4 clk = ~clk;

  two_stack_insertion_sorter #(
    .MAX_ITEMS(CAPACITY)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  two_stack_insertion_sorter_checker #(
    .MAX_ITEMS(CAPACITY)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .strobe       (strobe),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // The watchdog restarts whenever a transaction moves in either direction,
  // so a hung block ends the run instead of stalling it forever.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one value and returns on the falling edge after it was taken.
  // Start stays high between back-to-back transactions; an idle gap lowers
  // it on one falling edge and raises it again on a later one.
  task automatic offer_value(input logic signed [VALUE_W-1:0] v, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    item.value   <= v;
    item.is_last <= last;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  // Values lean on the extremes and on a narrow band so that duplicates
  // appear often; the rest are fully random patterns.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0:       v = 32'sh8000_0000;
      1:       v = 32'sh7fff_ffff;
      2:       v = 32'sh8000_0000 + $urandom_range(3);
      3:       v = 32'sh7fff_ffff - $urandom_range(3);
      4, 5:    v = $signed($urandom_range(8)) - 4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic sort_random_batch();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 55)      n = $urandom_range(6, 1);
    else if (pick < 78) n = $urandom_range(CAPACITY - 1, 7);
    else if (pick < 88) n = CAPACITY;
    else                n = $urandom_range(CAPACITY + 8, CAPACITY + 1);
    for (int i = 0; i < n; i++) offer_value(pick_value(), i == n - 1);
    batches_sent++;
    if (n > CAPACITY) overflow_batches++;
  endtask

  initial begin
    logic signed [VALUE_W-1:0] mixed_batch [7];
    int                        phase_start;
    mixed_batch = '{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 5, 5, -1};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Both extremes, zero and duplicates in one batch, out of order.
    for (int i = 0; i < 7; i++) offer_value(mixed_batch[i], i == 6);
    batches_sent++;

    // A batch of a single value.
    offer_value(0, 1'b1);
    batches_sent++;

    // Fill the store in descending order, then close the batch with a value
    // that finds the store full: it must be dropped, yet the batch must still
    // come out, with overflow on every result.
    for (int i = 0; i < CAPACITY; i++) offer_value(CAPACITY - 1 - i, 1'b0);
    offer_value(32'sh8000_0000, 1'b1);
    batches_sent++;
    overflow_batches++;

    // Random batches: moderate sender idling, then heavy, then none.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 16 : (p == 1) ? 81 : 0;
      phase_start   = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) sort_random_batch();
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d values in %0d batches, %0d of them over capacity.",
             items_sent, batches_sent, overflow_batches);
    $display("Checked %0d sorted results with %0d mismatches.",
             results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tsis_pkg.sv
hw/rtl/tsis_cell.sv
hw/rtl/two_stack_insertion_sorter.sv
sim/two_stack_insertion_sorter_checker.sv
sim/two_stack_insertion_sorter_tb.sv
